### design/volume_convolution_3d_assert.svh
// Assertion macros for the volume convolution block.
// Used by the top level only; no other dependencies.
`ifndef VOLUME_CONVOLUTION_3D_ASSERT_SVH
`define VOLUME_CONVOLUTION_3D_ASSERT_SVH
`ifndef SYNTHESIS
`define VC_ASSERT_IMPL(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define VC_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define VC_ASSERT_IMPL(label, clk, rst_n, cond, msg)
`define VC_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

### design/vconv_pkg.sv
// Shared types and constants for the volume convolution block.
// No dependencies.
package vconv_pkg;
	localparam logic [1:0] OP_WR_VOXEL  = 2'd0;
	localparam logic [1:0] OP_WR_WEIGHT = 2'd1;
	localparam logic [1:0] OP_COMPUTE   = 2'd2;

	localparam logic [1:0] REG_DEPTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_WIDTH  = 2'd2;
	localparam logic [1:0] REG_RADIUS = 2'd3;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [4:0]         coord_z;
		logic [4:0]         coord_y;
		logic [4:0]         coord_x;
		logic signed [15:0] value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] result;
		logic               status;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture request
		logic wr_voxel;
		logic wr_weight;
		logic start;     // clear window counters and accumulator
		logic step;      // issue one tap read, advance counters
		logic fin;       // compute shifted result
		logic err;       // result zero, status one
		logic push;      // move result into output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic vox_ok;
		logic wgt_ok;
		logic last_tap;
		logic drained;
	} sts_t;
endpackage

### design/vconv_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module vconv_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

### design/vconv_datapath.sv
// Datapath: stores, window address generation, multiply-accumulate.
// Depends on vconv_pkg and vconv_ram.
module vconv_datapath
	import vconv_pkg::*;
#(
	parameter int MAX_EDGE   = 32,
	parameter int MAX_RADIUS = 3
) (
	input  logic clk,
	input  logic arst_n,
	input  req_t req,
	input  logic [5:0] cfg_depth,
	input  logic [5:0] cfg_height,
	input  logic [5:0] cfg_width,
	input  logic [1:0] cfg_radius,
	input  cmd_t cmd,
	output sts_t sts,
	output rsp_t rsp
);
	localparam int EB    = $clog2(MAX_EDGE) > 0 ? $clog2(MAX_EDGE) : 1;
	localparam int KEDGE = 2 * MAX_RADIUS + 1;
	localparam int KB    = $clog2(KEDGE) > 0 ? $clog2(KEDGE) : 1;
	localparam int VDEP  = MAX_EDGE * MAX_EDGE * MAX_EDGE;
	localparam int WDEP  = KEDGE * KEDGE * KEDGE;
	localparam int VAB   = $clog2(VDEP) > 0 ? $clog2(VDEP) : 1;
	localparam int WAB   = $clog2(WDEP) > 0 ? $clog2(WDEP) : 1;
	localparam int CB    = 10;

	req_t req_q;
	logic [3:0] kz_q, ky_q, kx_q;
	logic signed [47:0] acc_q;
	logic v_s1, v_s2;
	logic signed [31:0] prod_s2;
	logic signed [31:0] res_q;
	logic stat_q;
	rsp_t out_q;

	logic [CB-1:0] dd, hh, ww;
	logic [3:0] rr, ke;
	always_comb begin
		dd = (cfg_depth == 6'd0) ? CB'(1) : (CB'(cfg_depth) > CB'(MAX_EDGE) ?
			CB'(MAX_EDGE) : CB'(cfg_depth));
		hh = (cfg_height == 6'd0) ? CB'(1) : (CB'(cfg_height) > CB'(MAX_EDGE) ?
			CB'(MAX_EDGE) : CB'(cfg_height));
		ww = (cfg_width == 6'd0) ? CB'(1) : (CB'(cfg_width) > CB'(MAX_EDGE) ?
			CB'(MAX_EDGE) : CB'(cfg_width));
		rr = (4'(cfg_radius) > 4'(MAX_RADIUS)) ? 4'(MAX_RADIUS) : 4'(cfg_radius);
		ke = 4'((rr << 1) + 4'd1);
	end

	always_comb begin
		sts.vox_ok = (CB'(req_q.coord_z) < dd) && (CB'(req_q.coord_y) < hh) &&
			(CB'(req_q.coord_x) < ww);
		sts.wgt_ok = (5'(req_q.coord_z) < 5'(ke)) && (5'(req_q.coord_y) < 5'(ke)) &&
			(5'(req_q.coord_x) < 5'(ke));
		sts.last_tap = (kz_q == ke - 4'd1) && (ky_q == ke - 4'd1) && (kx_q == ke - 4'd1);
		sts.drained = !v_s1 && !v_s2;
	end

	// window position, signed offsets
	logic signed [CB:0] pz, py, px;
	logic inb;
	always_comb begin
		pz = $signed({1'b0, CB'(req_q.coord_z)}) + $signed({1'b0, 6'(kz_q)})
			- $signed({1'b0, 6'(rr)});
		py = $signed({1'b0, CB'(req_q.coord_y)}) + $signed({1'b0, 6'(ky_q)})
			- $signed({1'b0, 6'(rr)});
		px = $signed({1'b0, CB'(req_q.coord_x)}) + $signed({1'b0, 6'(kx_q)})
			- $signed({1'b0, 6'(rr)});
		inb = (pz >= 0) && (pz < $signed({1'b0, dd})) && (py >= 0) &&
			(py < $signed({1'b0, hh})) && (px >= 0) && (px < $signed({1'b0, ww}));
	end

	logic [VAB-1:0] v_waddr, v_raddr;
	logic [WAB-1:0] w_waddr, w_raddr;
	logic [15:0] v_rdata, w_rdata;
	always_comb begin
		v_waddr = VAB'((VAB'(req_q.coord_z) * VAB'(MAX_EDGE) + VAB'(req_q.coord_y))
			* VAB'(MAX_EDGE) + VAB'(req_q.coord_x));
		w_waddr = WAB'((WAB'(req_q.coord_z) * WAB'(KEDGE) + WAB'(req_q.coord_y))
			* WAB'(KEDGE) + WAB'(req_q.coord_x));
		v_raddr = VAB'((VAB'(pz[EB-1:0]) * VAB'(MAX_EDGE) + VAB'(py[EB-1:0]))
			* VAB'(MAX_EDGE) + VAB'(px[EB-1:0]));
		w_raddr = WAB'((WAB'(kz_q) * WAB'(KEDGE) + WAB'(ky_q)) * WAB'(KEDGE)
			+ WAB'(kx_q));
	end

	vconv_ram #(.WIDTH(16), .DEPTH(VDEP)) u_vox (
		.clk(clk), .we(cmd.wr_voxel), .waddr(v_waddr), .wdata(req_q.value),
		.raddr(v_raddr), .rdata(v_rdata)
	);
	vconv_ram #(.WIDTH(16), .DEPTH(WDEP)) u_wgt (
		.clk(clk), .we(cmd.wr_weight), .waddr(w_waddr), .wdata(req_q.value),
		.raddr(w_raddr), .rdata(w_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load)
			req_q <= req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kz_q <= '0; ky_q <= '0; kx_q <= '0;
			v_s1 <= 1'b0; v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.step && inb;
			v_s2 <= v_s1;
			if (cmd.start) begin
				kz_q <= '0; ky_q <= '0; kx_q <= '0;
			end else if (cmd.step) begin
				if (kx_q == ke - 4'd1) begin
					kx_q <= '0;
					if (ky_q == ke - 4'd1) begin
						ky_q <= '0;
						kz_q <= kz_q + 4'd1;
					end else
						ky_q <= ky_q + 4'd1;
				end else
					kx_q <= kx_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= $signed(v_rdata) * $signed(w_rdata);
		if (cmd.start)
			acc_q <= '0;
		else if (v_s2)
			acc_q <= acc_q + 48'(prod_s2);
		if (cmd.fin) begin
			res_q  <= 32'(acc_q >>> 14);
			stat_q <= 1'b0;
		end else if (cmd.err || cmd.wr_voxel || cmd.wr_weight) begin
			res_q  <= '0;
			stat_q <= cmd.err;
		end
		if (cmd.push) begin
			out_q.result <= res_q;
			out_q.status <= stat_q;
		end
	end

	assign rsp = out_q;
endmodule

### design/vconv_ctrl.sv
// Controller state machine: sequences writes and window taps, handles handshake.
// Depends on vconv_pkg.
module vconv_ctrl
	import vconv_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic [1:0] opcode,
	input  sts_t sts,
	input  logic out_stall,
	output logic in_stall,
	output logic out_valid,
	output cmd_t cmd
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEC  = 3'd1;
	localparam logic [2:0] S_RUN  = 3'd2;
	localparam logic [2:0] S_WAIT = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0] state_q, state_d;
	logic [1:0] op_q;
	logic ov_q;
	logic dec_ok;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = ov_q;
	assign dec_ok    = (op_q == OP_WR_WEIGHT) ? sts.wgt_ok : sts.vox_ok;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid && !in_stall) begin
				cmd.load = 1'b1;
				state_d = S_DEC;
			end
			S_DEC: begin
				if (op_q == OP_WR_VOXEL && dec_ok) cmd.wr_voxel = 1'b1;
				else if (op_q == OP_WR_WEIGHT && dec_ok) cmd.wr_weight = 1'b1;
				else if (op_q == OP_COMPUTE && dec_ok) cmd.start = 1'b1;
				else cmd.err = 1'b1;
				state_d = (op_q == OP_COMPUTE && dec_ok) ? S_RUN : S_OUT;
			end
			S_RUN: begin
				cmd.step = 1'b1;
				if (sts.last_tap) state_d = S_WAIT;
			end
			S_WAIT: if (sts.drained) begin
				cmd.fin = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: if (!ov_q || !out_stall) begin
				cmd.push = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= '0;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load)
				op_q <= opcode;
			if (cmd.push)
				ov_q <= 1'b1;
			else if (ov_q && !out_stall)
				ov_q <= 1'b0;
		end
	end
endmodule

### design/volume_convolution_3d.sv
// A write or rejected request goes through the decode and output states; a compute steps
// every tap, one tap per cycle through one read port per store, one multiplier.
// A new request is taken only once the last one has reached the output register; a stalled
// response waits in the output register and holds back only the next result transfer.
// Reset clears control and loads the default register values; the stores are not cleared.
// Top level: config registers, controller, datapath. Uses vconv_pkg.
`include "volume_convolution_3d_assert.svh"
module volume_convolution_3d
	import vconv_pkg::*;
#(
	parameter int MAX_EDGE   = 32,
	parameter int MAX_RADIUS = 3
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  req_t       in_data,
	output logic       out_valid,
	input  logic       out_stall,
	output rsp_t       out_data,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [5:0] cfg_data
);
	logic [5:0] depth_q, height_q, width_q;
	logic [1:0] radius_q;
	cmd_t cmd;
	sts_t sts;
	rsp_t rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= 6'd32; height_q <= 6'd32; width_q <= 6'd32; radius_q <= 2'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEPTH:  depth_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				REG_WIDTH:  width_q  <= cfg_data;
				REG_RADIUS: radius_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	vconv_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .opcode(in_data.opcode),
		.sts(sts), .out_stall(out_stall), .in_stall(in_stall),
		.out_valid(out_valid), .cmd(cmd)
	);

	vconv_datapath #(.MAX_EDGE(MAX_EDGE), .MAX_RADIUS(MAX_RADIUS)) u_dp (
		.clk(clk), .arst_n(arst_n), .req(in_data), .cfg_depth(depth_q),
		.cfg_height(height_q), .cfg_width(width_q), .cfg_radius(radius_q),
		.cmd(cmd), .sts(sts), .rsp(rsp)
	);

	assign out_data = rsp;

	`VC_ASSERT_IMPL(a_one_cmd, clk, arst_n, $onehot0({cmd.load, cmd.wr_voxel, cmd.wr_weight, cmd.start, cmd.step, cmd.fin, cmd.err, cmd.push}), "conflicting commands")
	`VC_ASSERT_IMPL(a_busy_stall, clk, arst_n, !(cmd.step && !in_stall), "request taken mid compute")
	`VC_ASSERT_NEXT(a_fin_out, clk, arst_n, cmd.fin, !cmd.load, "load right after finish")
endmodule

### dv/vconv_checker.sv
// Checker for volume_convolution_3d: watches request and response channels,
// predicts each response from its own copy of the stores and registers. Uses vconv_pkg.
module vconv_checker
	import vconv_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  req_t       in_data,
	input  logic       out_valid,
	input  logic       out_stall,
	input  rsp_t       out_data,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [5:0] cfg_data,
	output int         fail_count,
	output int         pending,
	output int         n_compute
);
	logic [15:0] vox_mem [0:32767];
	logic [15:0] wgt_mem [0:342];
	logic [5:0]  r_depth, r_height, r_width;
	logic [1:0]  r_radius;
	rsp_t        rsp_q [$];

	function automatic int eff_edge(logic [5:0] v);
		if (v == 0) return 1;
		if (v > 32) return 32;
		return int'(v);
	endfunction

	function automatic rsp_t conv_predict(req_t q);
		rsp_t        p;
		int          dd, hh, ww, r, ke, pz, py, px;
		logic signed [63:0] acc;
		dd = eff_edge(r_depth);
		hh = eff_edge(r_height);
		ww = eff_edge(r_width);
		r = int'(r_radius);
		ke = 2 * r + 1;
		p.result = '0;
		p.status = 1'b0;
		acc = 0;
		case (q.opcode)
			OP_WR_VOXEL: begin
				if (q.coord_z < dd && q.coord_y < hh && q.coord_x < ww)
					vox_mem[{q.coord_z, q.coord_y, q.coord_x}] = q.value;
				else
					p.status = 1'b1;
			end
			OP_WR_WEIGHT: begin
				if (q.coord_z < ke && q.coord_y < ke && q.coord_x < ke)
					wgt_mem[(q.coord_z * 7 + q.coord_y) * 7 + q.coord_x] = q.value;
				else
					p.status = 1'b1;
			end
			OP_COMPUTE: begin
				if (q.coord_z < dd && q.coord_y < hh && q.coord_x < ww) begin
					for (int kz = 0; kz < ke; kz++)
						for (int ky = 0; ky < ke; ky++)
							for (int kx = 0; kx < ke; kx++) begin
								pz = q.coord_z + kz - r;
								py = q.coord_y + ky - r;
								px = q.coord_x + kx - r;
								if (pz >= 0 && pz < dd && py >= 0 && py < hh && px >= 0 && px < ww)
									acc += 64'(signed'(vox_mem[(pz * 32 + py) * 32 + px])) *
										64'(signed'(wgt_mem[(kz * 7 + ky) * 7 + kx]));
							end
					p.result = 32'(acc >>> 14);
				end else begin
					p.status = 1'b1;
				end
			end
			default: p.status = 1'b1;
		endcase
		return p;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_depth <= 6'd32;
			r_height <= 6'd32;
			r_width <= 6'd32;
			r_radius <= 2'd1;
			fail_count <= 0;
			n_compute <= 0;
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (rsp_q.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10)
						$display("unexpected response %h/%0d", out_data.result, out_data.status);
				end else begin
					if (rsp_q[0] !== out_data) begin
						fail_count <= fail_count + 1;
						if (fail_count < 10)
							$display("mismatch: exp %h/%0d got %h/%0d", rsp_q[0].result,
								rsp_q[0].status, out_data.result, out_data.status);
					end
					void'(rsp_q.pop_front());
				end
			end
			if (in_valid && !in_stall) begin
				if (in_data.opcode == OP_COMPUTE)
					n_compute <= n_compute + 1;
				rsp_q.push_back(conv_predict(in_data));
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_DEPTH:  r_depth <= cfg_data;
					REG_HEIGHT: r_height <= cfg_data;
					REG_WIDTH:  r_width <= cfg_data;
					REG_RADIUS: r_radius <= cfg_data[1:0];
				endcase
			end
			pending <= rsp_q.size();
		end
	end
endmodule

### dv/tb.sv
// Testbench top for volume_convolution_3d: directed and random requests over
// several volume and kernel settings, random idling on both sides. Uses vconv_checker.
module tb;
	import vconv_pkg::*;

	logic       clk = 0;
	logic       arst_n = 0;
	logic       in_valid = 0;
	logic       in_stall;
	req_t       in_data = '0;
	logic       out_valid;
	logic       out_stall;
	rsp_t       out_data;
	logic       cfg_we = 0;
	logic [1:0] cfg_index = REG_DEPTH;
	logic [5:0] cfg_data = '0;
	int         fail_count, pending, n_compute;
	int         idle_cycles = 0;
	int         n_sent = 0;
	int         dd, hh, ww, rr;
	bit         vox_written [0:32767];
	bit         wgt_written [0:342];

	always #2 clk = ~clk;

	volume_convolution_3d u_dut (.*);

	vconv_checker u_chk (.*);

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// response side: stall each response randomly before accepting it
	initial begin : out_side
		int w;
		out_stall = 1'b1;
		w = $urandom_range(0, 6);
		forever begin
			@(negedge clk);
			if (out_valid) begin
				repeat (w) @(negedge clk);
				out_stall <= 1'b0;
				@(negedge clk);
				out_stall <= 1'b1;
				w = $urandom_range(0, 6);
			end
		end
	end

	task automatic send_request(logic [1:0] op, int z, int y, int x, logic [15:0] v);
		repeat ($urandom_range(0, 6)) @(negedge clk);
		in_data <= '{opcode: op, coord_z: 5'(z), coord_y: 5'(y), coord_x: 5'(x), value: v};
		in_valid <= 1'b1;
		#1;
		while (in_stall) begin
			@(negedge clk);
			#1;
		end
		@(negedge clk);
		in_valid <= 1'b0;
		n_sent++;
		if (op == OP_WR_VOXEL && z < dd && y < hh && x < ww)
			vox_written[(z * 32 + y) * 32 + x] = 1;
		if (op == OP_WR_WEIGHT && z <= 2 * rr && y <= 2 * rr && x <= 2 * rr)
			wgt_written[(z * 7 + y) * 7 + x] = 1;
	endtask

	task automatic drain();
		while (pending != 0) @(negedge clk);
		repeat (400) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [5:0] v);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	// volume and kernel setting: fill everything that compute may read
	task automatic set_shape(int d, int h, int w, int r);
		write_reg(REG_DEPTH, 6'(d));
		write_reg(REG_HEIGHT, 6'(h));
		write_reg(REG_WIDTH, 6'(w));
		write_reg(REG_RADIUS, 6'(r));
		dd = d; hh = h; ww = w; rr = r;
		for (int z = 0; z < d; z++)
			for (int y = 0; y < h; y++)
				for (int x = 0; x < w; x++)
					if (!vox_written[(z * 32 + y) * 32 + x])
						send_request(OP_WR_VOXEL, z, y, x, 16'($urandom));
		for (int z = 0; z <= 2 * r; z++)
			for (int y = 0; y <= 2 * r; y++)
				for (int x = 0; x <= 2 * r; x++)
					if (!wgt_written[(z * 7 + y) * 7 + x])
						send_request(OP_WR_WEIGHT, z, y, x, 16'($urandom));
	endtask

	task automatic random_phase(int n);
		int z, y, x, k;
		logic [15:0] v;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 9);
			z = $urandom_range(0, dd - 1);
			y = $urandom_range(0, hh - 1);
			x = $urandom_range(0, ww - 1);
			v = 16'($urandom);
			if (k < 5)
				send_request(OP_COMPUTE, z, y, x, v);
			else if (k < 7)
				send_request(OP_WR_VOXEL, z, y, x, v);
			else if (k < 8)
				send_request(OP_WR_WEIGHT, $urandom_range(0, 2 * rr), $urandom_range(0, 2 * rr),
					$urandom_range(0, 2 * rr), v);
			else if (k < 9)
				send_request(2'($urandom_range(0, 3)), $urandom_range(0, 31),
					$urandom_range(0, 31), $urandom_range(0, 31), v);
			else
				send_request(2'd3, z, y, x, v);
		end
	endtask

	initial begin
		dd = 32; hh = 32; ww = 32; rr = 1;
		repeat (4) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		// small volume, radius 1, then directed extremes
		set_shape(3, 4, 5, 1);
		send_request(OP_WR_VOXEL, 0, 0, 0, 16'h7fff);
		send_request(OP_WR_VOXEL, 2, 3, 4, 16'h8000);
		send_request(OP_WR_VOXEL, 3, 0, 0, 16'h1234);
		send_request(OP_WR_VOXEL, 31, 31, 31, 16'hffff);
		send_request(OP_WR_WEIGHT, 0, 0, 0, 16'h8000);
		send_request(OP_WR_WEIGHT, 2, 2, 2, 16'h7fff);
		send_request(OP_WR_WEIGHT, 3, 0, 0, 16'h0001);
		send_request(OP_WR_WEIGHT, 0, 0, 31, 16'h0001);
		send_request(OP_COMPUTE, 0, 0, 0, 16'hffff);
		send_request(OP_COMPUTE, 2, 3, 4, 16'h0);
		send_request(OP_COMPUTE, 1, 2, 2, 16'h0);
		send_request(OP_COMPUTE, 3, 0, 0, 16'h0);
		send_request(OP_COMPUTE, 31, 31, 31, 16'h0);
		send_request(2'd3, 0, 0, 0, 16'h5555);
		send_request(2'd3, 31, 31, 31, 16'haaaa);
		// pause until all responses are back
		drain();
		random_phase(60);
		drain();
		set_shape(1, 1, 1, 0);
		random_phase(30);
		drain();
		// zero registers act as one
		write_reg(REG_DEPTH, 6'd0);
		write_reg(REG_HEIGHT, 6'd0);
		write_reg(REG_WIDTH, 6'd0);
		dd = 1; hh = 1; ww = 1;
		random_phase(20);
		drain();
		// radius three over a 4x5x6 block, then radius two on the same block
		set_shape(4, 5, 6, 3);
		random_phase(120);
		drain();
		write_reg(REG_RADIUS, 6'd2);
		rr = 2;
		random_phase(60);
		drain();
		// full extent with oversized register values, corner of the volume
		write_reg(REG_DEPTH, 6'd63);
		write_reg(REG_HEIGHT, 6'd40);
		write_reg(REG_WIDTH, 6'd33);
		write_reg(REG_RADIUS, 6'd1);
		dd = 32; hh = 32; ww = 32; rr = 1;
		for (int i = 0; i < 8; i++)
			send_request(OP_WR_VOXEL, 30 + i / 4, 30 + (i / 2) % 2, 30 + i % 2, 16'($urandom));
		send_request(OP_COMPUTE, 31, 31, 31, 16'h0);
		for (int i = 0; i < 40; i++)
			send_request(OP_WR_VOXEL, 31, 31, 31 - i % 4, 16'($urandom));
		send_request(OP_COMPUTE, 31, 31, 31, 16'h0);
		drain();
		$display("sent %0d requests, %0d computes, volumes 1x1x1 to 32x32x32, radius 0 to 3",
			n_sent, n_compute);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
